### rtl/frf_pkg.sv
// Shared types and constants for the false-position root finder.
// Used by frf_div, frf_dp, frf_ctrl and the top level; no dependencies.
package frf_pkg;

  // Field and datapath widths
  localparam int XW       = 32;            // Q16.16 point and function value
  localparam int CNTW     = 16;            // iteration counter / limit
  localparam int TOLW     = 31;            // convergence tolerance
  localparam int CFG_IDXW = 1;             // config register index
  localparam int CFG_DW   = TOLW;          // config data, widest register
  localparam int PRODW    = 2 * XW;        // full product
  localparam int NUMW     = PRODW + 1;     // difference of two products
  localparam int DENW     = XW + 1;        // difference of two f values
  localparam int QW       = PRODW;         // quotient before saturation
  localparam int DIV_ITERS = QW / 2;       // two quotient bits per cycle
  localparam int DIV_CNTW  = $clog2(DIV_ITERS);

  // Config register indexes and reset values
  localparam logic [CFG_IDXW-1:0] CFG_ZERO_TOL   = 1'b0;
  localparam logic [CFG_IDXW-1:0] CFG_ITER_LIMIT = 1'b1;
  localparam logic [TOLW-1:0]     TOL_RESET      = 31'd7;
  localparam logic [CNTW-1:0]     LIMIT_RESET    = 16'd100;

  // Input beat kinds
  localparam logic IN_START = 1'b0;
  localparam logic IN_FVAL  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_EVAL     = 2'd0,
    ST_ROOT     = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_ZERO_DEN = 2'd3
  } status_t;

  // Source of the result point
  typedef enum logic [1:0] {
    RES_LEFT  = 2'd0,
    RES_RIGHT = 2'd1,
    RES_EST   = 2'd2,
    RES_ZERO  = 2'd3
  } res_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     ld_start;
    logic     ld_left_f;
    logic     ld_right_f;
    logic     step;
    logic     mul_a;
    logic     mul_b;
    logic     sub;
    logic     mag;
    logic     div_start;
    logic     est_load;
    logic     out_load;
    res_sel_t res_sel;
  } frf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cont;      // not converged and below the limit
    logic lim_hit;   // count at or above the limit
    logic den_zero;  // zero denominator
    logic div_done;  // quotient ready
  } frf_sts_t;

endpackage

### rtl/frf_div.sv
// Serial unsigned divider, 64-bit dividend by 33-bit divisor, radix 4.
// Depends on frf_pkg.
module frf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [frf_pkg::QW-1:0]     dividend,
  input  logic [frf_pkg::DENW-1:0]   divisor,
  output logic                       done,
  output logic [frf_pkg::QW-1:0]     quotient
);

  logic [frf_pkg::DENW-1:0]     rem_r;
  logic [frf_pkg::QW-1:0]       quo_r;
  logic [frf_pkg::DENW-1:0]     div_r;
  logic [frf_pkg::DIV_CNTW-1:0] cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [frf_pkg::DENW:0]       s1;
  logic [frf_pkg::DENW:0]       s2;

  // One restoring step: {quotient bit, new remainder}
  function automatic logic [frf_pkg::DENW:0] div_step(
    input logic [frf_pkg::DENW-1:0] rem,
    input logic                     nb,
    input logic [frf_pkg::DENW-1:0] d
  );
    logic [frf_pkg::DENW:0] t;
    logic [frf_pkg::DENW:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, d};
    if (!diff[frf_pkg::DENW]) begin
      div_step = {1'b1, diff[frf_pkg::DENW-1:0]};
    end else begin
      div_step = {1'b0, t[frf_pkg::DENW-1:0]};
    end
  endfunction

  // Two bits per cycle
  assign s1 = div_step(rem_r, quo_r[frf_pkg::QW-1], div_r);
  assign s2 = div_step(s1[frf_pkg::DENW-1:0], quo_r[frf_pkg::QW-2], div_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == frf_pkg::DIV_CNTW'(frf_pkg::DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift register: dividend bits leave at the top, quotient bits enter below
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= s2[frf_pkg::DENW-1:0];
      quo_r <= {quo_r[frf_pkg::QW-3:0], s1[frf_pkg::DENW], s2[frf_pkg::DENW]};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/frf_dp.sv
// Datapath: bracket registers, shared multiplier, magnitude stage,
// divider and result register. Depends on frf_pkg and frf_div.
module frf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [frf_pkg::CFG_IDXW-1:0]   cfg_index,
  input  logic [frf_pkg::CFG_DW-1:0]     cfg_data,
  input  logic signed [frf_pkg::XW-1:0]  in_x_low,
  input  logic signed [frf_pkg::XW-1:0]  in_x_high,
  input  logic signed [frf_pkg::XW-1:0]  in_f_value,
  input  frf_pkg::frf_cmd_t              cmd,
  output frf_pkg::frf_sts_t              sts,
  output logic signed [frf_pkg::XW-1:0]  out_x_value
);

  logic [frf_pkg::TOLW-1:0]        tol_r;
  logic [frf_pkg::CNTW-1:0]        limit_r;
  logic [frf_pkg::CNTW-1:0]        cnt_r;
  logic signed [frf_pkg::XW-1:0]   left_x_r;
  logic signed [frf_pkg::XW-1:0]   right_x_r;
  logic signed [frf_pkg::XW-1:0]   left_f_r;
  logic signed [frf_pkg::XW-1:0]   right_f_r;
  logic signed [frf_pkg::XW-1:0]   est_r;
  logic signed [frf_pkg::XW-1:0]   out_x_r;
  logic signed [frf_pkg::PRODW-1:0] prod_a_r;
  logic signed [frf_pkg::PRODW-1:0] prod_b_r;
  logic [frf_pkg::NUMW-1:0]        num_r;
  logic [frf_pkg::DENW-1:0]        den_r;
  logic [frf_pkg::QW-1:0]          un_r;
  logic [frf_pkg::DENW-1:0]        ud_r;
  logic                            neg_r;
  logic                            den_zero_r;

  logic signed [frf_pkg::XW-1:0]    mul_x;
  logic signed [frf_pkg::XW-1:0]    mul_f;
  logic signed [frf_pkg::PRODW-1:0] mul_p;
  logic [frf_pkg::NUMW-1:0]         num_abs;
  logic [frf_pkg::DENW-1:0]         den_abs;
  logic [frf_pkg::XW-1:0]           fv_mag;
  logic                             flip;
  logic                             div_done;
  logic [frf_pkg::QW-1:0]           quo;
  logic                             q_ovf;
  logic [frf_pkg::XW-1:0]           sat;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= frf_pkg::TOL_RESET;
      limit_r <= frf_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        frf_pkg::CFG_ZERO_TOL:   tol_r   <= cfg_data;
        frf_pkg::CFG_ITER_LIMIT: limit_r <= cfg_data[frf_pkg::CNTW-1:0];
        default: ;
      endcase
    end
  end

  // Convergence and limit checks on the returned value
  assign fv_mag = in_f_value[frf_pkg::XW-1] ? (frf_pkg::XW'(0) - in_f_value) : in_f_value;
  assign sts.cont = (fv_mag > {1'b0, tol_r}) && (cnt_r < limit_r);
  assign sts.lim_hit  = (cnt_r >= limit_r);
  assign sts.den_zero = den_zero_r;
  assign sts.div_done = div_done;

  // Product of the old left f and the new f is negative
  assign flip = (left_f_r[frf_pkg::XW-1] != in_f_value[frf_pkg::XW-1]) &&
                (left_f_r != '0) && (in_f_value != '0);

  // Bracket and iteration count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.ld_start) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_start) begin
      left_x_r  <= in_x_low;
      right_x_r <= in_x_high;
    end
    if (cmd.ld_left_f) begin
      left_f_r <= in_f_value;
    end
    if (cmd.ld_right_f) begin
      right_f_r <= in_f_value;
    end
    if (cmd.step) begin
      if (flip) begin
        right_x_r <= est_r;
        right_f_r <= in_f_value;
      end else begin
        left_x_r <= est_r;
        left_f_r <= in_f_value;
      end
    end
  end

  // Shared 32x32 multiplier, one product per cycle
  assign mul_x = cmd.mul_a ? right_x_r : left_x_r;
  assign mul_f = cmd.mul_a ? left_f_r  : right_f_r;
  assign mul_p = mul_x * mul_f;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      prod_a_r <= mul_p;
    end
    if (cmd.mul_b) begin
      prod_b_r <= mul_p;
    end
  end

  // Numerator and denominator
  always_ff @(posedge clk) begin
    if (cmd.sub) begin
      num_r <= {prod_a_r[frf_pkg::PRODW-1], prod_a_r} - {prod_b_r[frf_pkg::PRODW-1], prod_b_r};
      den_r <= {left_f_r[frf_pkg::XW-1], left_f_r} - {right_f_r[frf_pkg::XW-1], right_f_r};
    end
  end

  // Magnitudes and quotient sign
  assign num_abs = num_r[frf_pkg::NUMW-1] ? (frf_pkg::NUMW'(0) - num_r) : num_r;
  assign den_abs = den_r[frf_pkg::DENW-1] ? (frf_pkg::DENW'(0) - den_r) : den_r;

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      un_r       <= num_abs[frf_pkg::QW-1:0];
      ud_r       <= den_abs;
      neg_r      <= num_r[frf_pkg::NUMW-1] ^ den_r[frf_pkg::DENW-1];
      den_zero_r <= (den_r == '0);
    end
  end

  frf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (un_r),
    .divisor  (ud_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Saturate the signed quotient to 32 bits
  assign q_ovf = |quo[frf_pkg::QW-1:frf_pkg::XW-1];
  always_comb begin
    if (neg_r) begin
      sat = q_ovf ? {1'b1, {(frf_pkg::XW-1){1'b0}}} : (frf_pkg::XW'(0) - quo[frf_pkg::XW-1:0]);
    end else begin
      sat = q_ovf ? {1'b0, {(frf_pkg::XW-1){1'b1}}} : quo[frf_pkg::XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.est_load) begin
      est_r <= sat;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        frf_pkg::RES_LEFT:  out_x_r <= left_x_r;
        frf_pkg::RES_RIGHT: out_x_r <= right_x_r;
        frf_pkg::RES_EST:   out_x_r <= est_r;
        default:            out_x_r <= '0;
      endcase
    end
  end

  assign out_x_value = out_x_r;

endmodule

### rtl/frf_ctrl.sv
// Controller: search phase, estimate sequencing and result handshake.
// Depends on frf_pkg.
module frf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  input  frf_pkg::frf_sts_t sts,
  output frf_pkg::frf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_WAIT, S_MUL_A, S_MUL_B, S_SUB, S_MAG, S_CHK, S_DIV, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_LEFT, PH_RIGHT, PH_EST
  } phase_t;

  state_t            state_r,      state_nxt;
  phase_t            phase_r,      phase_nxt;
  frf_pkg::status_t  res_status_r, res_status_nxt;
  frf_pkg::res_sel_t res_sel_r,    res_sel_nxt;
  frf_pkg::status_t  out_status_r, out_status_nxt;
  logic              out_valid_r,  out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    res_status_nxt = res_status_r;
    res_sel_nxt    = res_sel_r;
    out_status_nxt = out_status_r;
    cmd            = '0;
    cmd.res_sel    = res_sel_r;

    unique case (state_r)
      S_WAIT: begin
        if (in_valid) begin
          if (in_func == frf_pkg::IN_START) begin
            cmd.ld_start   = 1'b1;
            phase_nxt      = PH_LEFT;
            res_status_nxt = frf_pkg::ST_EVAL;
            res_sel_nxt    = frf_pkg::RES_LEFT;
            state_nxt      = S_EMIT;
          end else begin
            unique case (phase_r)
              PH_IDLE: ;
              PH_LEFT: begin
                cmd.ld_left_f  = 1'b1;
                phase_nxt      = PH_RIGHT;
                res_status_nxt = frf_pkg::ST_EVAL;
                res_sel_nxt    = frf_pkg::RES_RIGHT;
                state_nxt      = S_EMIT;
              end
              PH_RIGHT: begin
                cmd.ld_right_f = 1'b1;
                state_nxt      = S_MUL_A;
              end
              PH_EST: begin
                if (sts.cont) begin
                  cmd.step  = 1'b1;
                  state_nxt = S_MUL_A;
                end else begin
                  phase_nxt      = PH_IDLE;
                  res_status_nxt = sts.lim_hit ? frf_pkg::ST_LIMIT : frf_pkg::ST_ROOT;
                  res_sel_nxt    = frf_pkg::RES_EST;
                  state_nxt      = S_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.den_zero) begin
          phase_nxt      = PH_IDLE;
          res_status_nxt = frf_pkg::ST_ZERO_DEN;
          res_sel_nxt    = frf_pkg::RES_ZERO;
          state_nxt      = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.est_load   = 1'b1;
          phase_nxt      = PH_EST;
          res_status_nxt = frf_pkg::ST_EVAL;
          res_sel_nxt    = frf_pkg::RES_EST;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          out_status_nxt = res_status_r;
          state_nxt      = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase

    // Output register valid
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_WAIT;
      phase_r      <= PH_IDLE;
      res_status_r <= frf_pkg::ST_EVAL;
      res_sel_r    <= frf_pkg::RES_ZERO;
      out_status_r <= frf_pkg::ST_EVAL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      res_status_r <= res_status_nxt;
      res_sel_r    <= res_sel_nxt;
      out_status_r <= out_status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_ready   = (state_r == S_WAIT);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  // Quotient only arrives while waiting for it
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  // A pending result beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while holding an untaken beat");

  // A final status ends the run
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && res_status_r != frf_pkg::ST_EVAL) |=> phase_r == PH_IDLE)
    else $error("run still active after a final result");

  // A returned value with no run active is dropped
  a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && in_valid && in_func == frf_pkg::IN_FVAL && phase_r == PH_IDLE)
    |=> state_r == S_WAIT)
    else $error("value beat with no active run produced work");
`endif

endmodule

### rtl/false_position_root_finder.sv
// False-position root finder, Q16.16; joins frf_ctrl and frf_dp (uses frf_pkg).
// A start or left-end value goes through S_EMIT to the output register; a right-end or estimate
// value that needs a new estimate first passes S_MUL_A, S_MUL_B, S_SUB, S_MAG, S_CHK and
// the radix-4 divider (S_DIV), which is skipped when the denominator is zero.
// One item is in work at a time; input is taken again once the result is in the output register.
// Reset (rst_n, synchronous, active low) idles the search, empties the output, sets
// zero_tol to 7 and iter_limit to 100.
module false_position_root_finder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [frf_pkg::CFG_IDXW-1:0]   cfg_index,
  input  logic [frf_pkg::CFG_DW-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic signed [frf_pkg::XW-1:0]  in_x_low,
  input  logic signed [frf_pkg::XW-1:0]  in_x_high,
  input  logic signed [frf_pkg::XW-1:0]  in_f_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic signed [frf_pkg::XW-1:0]  out_x_value
);

  frf_pkg::frf_cmd_t cmd;
  frf_pkg::frf_sts_t sts;

  frf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_func    (in_func),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .sts        (sts),
    .cmd        (cmd)
  );

  frf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_x_low    (in_x_low),
    .in_x_high   (in_x_high),
    .in_f_value  (in_f_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_x_value (out_x_value)
  );

endmodule
